[src/obpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package obpc_pkg;

  localparam int COMP_W     = 20;
  localparam int VEC_W      = 60;
  localparam int POS_W      = 32;
  localparam int HULL_W     = 24;
  localparam int PASS_W     = 28;
  localparam int PROJ_W     = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int ROOT_W     = 25;
  localparam longint TOL_Q36 = 68719;

  localparam logic [CFG_IDX_W-1:0] CFG_HULL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HULL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HULL_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HULL_CLR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_HALF_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_HALF_H = 3'd5;

  localparam logic [2:0] ST_INVALID     = 3'd0;
  localparam logic [2:0] ST_TOO_WIDE    = 3'd1;
  localparam logic [2:0] ST_TOO_TALL    = 3'd2;
  localparam logic [2:0] ST_OFFSET_OUT  = 3'd3;
  localparam logic [2:0] ST_FITS        = 3'd4;

  // vector pairs checked per basis: rr, uu, ff, ru, rf, uf
  localparam int PAIR_A [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [6] = '{0, 1, 2, 1, 2, 2};

  typedef enum logic [1:0] {
    RAD_IDLE,
    RAD_SQUARE,
    RAD_ROOT
  } rad_state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pose_center_x;
    logic signed [POS_W-1:0] pose_center_y;
    logic signed [POS_W-1:0] pose_center_z;
    logic signed [POS_W-1:0] gate_center_x;
    logic signed [POS_W-1:0] gate_center_y;
    logic signed [POS_W-1:0] gate_center_z;
    logic [VEC_W-1:0] body_right;
    logic [VEC_W-1:0] body_up;
    logic [VEC_W-1:0] body_forward;
    logic [VEC_W-1:0] gate_right;
    logic [VEC_W-1:0] gate_up;
    logic [VEC_W-1:0] gate_forward;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic fits;
    logic sphere_fits;
    logic signed [31:0] lateral_offset;
    logic signed [31:0] vertical_offset;
    logic [PROJ_W-1:0] projected_half_width;
    logic [PROJ_W-1:0] projected_half_height;
    logic signed [31:0] width_clearance;
    logic signed [31:0] height_clearance;
  } out_t;

endpackage
`default_nettype wire

[src/oriented_box_passage_clearance_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// oriented box passage clearance core
// in channel (in_valid/in_ready/in_data) takes one pose and passage frame per transaction;
// out channel (out_valid/out_ready/out_data) returns one result per transaction, in order.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes hull and passage registers;
// cfg_ready is high outside reset, indexes past the register list are ignored.
// each input transaction passes to its result valid through a seven stage
// pipeline (unpack, products, dot sums, rounding, extent products, extent sums, output).
// throughput: one transaction per cycle unless the receiver stalls or the radius unit
// is busy; every stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so a stalled receiver backs up the pipeline without losing or
// repeating anything and bubbles are squeezed out. a write to a hull half extent starts
// the bounding sphere radius unit (squaring, then root digits) and in_ready is held low.
// reset holds in_ready and cfg_ready low, clears the configuration registers to zero,
// empties the pipeline and leaves the radius at zero.
module oriented_box_passage_clearance_core import obpc_pkg::*; #(
  parameter int BASIS_FRAC_BITS = 18
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int F   = BASIS_FRAC_BITS;
  localparam int CW  = 40 - F;
  localparam int PW  = CW + 27 - F;
  localparam int LW  = 55;
  localparam int CLW = 60;
  localparam logic [79:0] TOL_W = (80'(TOL_Q36) << (2 * F)) >> 36;
  localparam logic signed [42:0] TOL  = $signed(43'(TOL_W));
  localparam logic signed [42:0] UNIT = $signed(43'(1) << (2 * F));
  localparam logic [41:0] HALF_D = 42'(1) << (F - 1);
  localparam logic signed [LW-1:0] HALF_L = $signed(LW'(1) << (F - 1));
  localparam logic [CW+25:0] HALF_P = (CW + 26)'(1) << (F - 1);

  logic [HULL_W-1:0] hull_x, hull_y, hull_z, hull_clr;
  logic [PASS_W-1:0] pass_w, pass_h;
  logic              rad_start, rad_busy;
  logic [ROOT_W-1:0] rad_root;

  assign cfg_ready = !rst;
  assign rad_start = cfg_valid && cfg_ready &&
                     (cfg_index == CFG_HULL_X || cfg_index == CFG_HULL_Y ||
                      cfg_index == CFG_HULL_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      hull_x   <= '0;
      hull_y   <= '0;
      hull_z   <= '0;
      hull_clr <= '0;
      pass_w   <= '0;
      pass_h   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HULL_X:      hull_x   <= cfg_data[HULL_W-1:0];
        CFG_HULL_Y:      hull_y   <= cfg_data[HULL_W-1:0];
        CFG_HULL_Z:      hull_z   <= cfg_data[HULL_W-1:0];
        CFG_HULL_CLR:    hull_clr <= cfg_data[HULL_W-1:0];
        CFG_PASS_HALF_W: pass_w   <= cfg_data;
        CFG_PASS_HALF_H: pass_h   <= cfg_data;
        default: ;
      endcase
    end
  end

  obpc_radius u_radius (
    .clk   (clk),
    .rst   (rst),
    .start (rad_start),
    .hx    (hull_x),
    .hy    (hull_y),
    .hz    (hull_z),
    .busy  (rad_busy),
    .root  (rad_root)
  );

  // stage valid and ready chain
  logic [7:1] v;
  logic [7:1] rdy;
  logic       in_fire;

  always_comb begin
    rdy[7] = !v[7] || out_ready;
    for (int k = 6; k >= 1; k--) rdy[k] = !v[k] || rdy[k+1];
  end

  assign in_ready  = rdy[1] && !rad_busy && !rst;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_fire;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: unpack and relative position
  logic [VEC_W-1:0] in_vec [6];
  logic signed [COMP_W-1:0] vec1 [6][3];
  logic signed [POS_W:0] rel1 [3];

  always_comb begin
    in_vec[0] = in_data.body_right;
    in_vec[1] = in_data.body_up;
    in_vec[2] = in_data.body_forward;
    in_vec[3] = in_data.gate_right;
    in_vec[4] = in_data.gate_up;
    in_vec[5] = in_data.gate_forward;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 6; i++) begin
        for (int t = 0; t < 3; t++) vec1[i][t] <= $signed(in_vec[i][COMP_W*t +: COMP_W]);
      end
      rel1[0] <= (POS_W+1)'($signed(in_data.pose_center_x)) -
                 (POS_W+1)'($signed(in_data.gate_center_x));
      rel1[1] <= (POS_W+1)'($signed(in_data.pose_center_y)) -
                 (POS_W+1)'($signed(in_data.gate_center_y));
      rel1[2] <= (POS_W+1)'($signed(in_data.pose_center_z)) -
                 (POS_W+1)'($signed(in_data.gate_center_z));
    end
  end

  // stage 2: products
  logic signed [39:0] pb2 [2][6][3];
  logic signed [39:0] pj2 [2][3][3];
  logic signed [52:0] pr2 [2][3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int t = 0; t < 3; t++) begin
        for (int b = 0; b < 2; b++) begin
          for (int p = 0; p < 6; p++) begin
            pb2[b][p][t] <= vec1[3*b+PAIR_A[p]][t] * vec1[3*b+PAIR_B[p]][t];
          end
        end
        for (int a = 0; a < 2; a++) begin
          for (int i = 0; i < 3; i++) pj2[a][i][t] <= vec1[i][t] * vec1[3+a][t];
          pr2[a][t] <= rel1[t] * vec1[3+a][t];
        end
      end
    end
  end

  // stage 3: dot sums
  logic signed [41:0] pd3 [2][6];
  logic signed [41:0] pj3 [2][3];
  logic signed [LW-1:0] pr3 [2];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int b = 0; b < 2; b++) begin
        for (int p = 0; p < 6; p++) begin
          pd3[b][p] <= 42'(pb2[b][p][0]) + 42'(pb2[b][p][1]) + 42'(pb2[b][p][2]);
        end
      end
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          pj3[a][i] <= 42'(pj2[a][i][0]) + 42'(pj2[a][i][1]) + 42'(pj2[a][i][2]);
        end
        pr3[a] <= LW'(pr2[a][0]) + LW'(pr2[a][1]) + LW'(pr2[a][2]);
      end
    end
  end

  // stage 4: basis and passage size checks, offset rounding, direction cosines
  logic ok4_next;
  logic signed [LW-1:0] lat4_next [2];
  logic [CW-1:0] c4_next [2][3];
  logic ok4;
  logic signed [LW-1:0] lat4 [2];
  logic [CW-1:0] c4 [2][3];

  always_comb begin
    logic signed [42:0] d;
    logic [41:0] mag;
    logic [41:0] rnd;
    ok4_next = (pass_w != '0) && (pass_h != '0);
    for (int b = 0; b < 2; b++) begin
      for (int p = 0; p < 6; p++) begin
        d = 43'(pd3[b][p]) - ((p < 3) ? UNIT : 43'sd0);
        if (d > TOL || d < -TOL) ok4_next = 1'b0;
      end
    end
    for (int a = 0; a < 2; a++) begin
      lat4_next[a] = (pr3[a] + HALF_L) >>> F;
      for (int i = 0; i < 3; i++) begin
        mag = pj3[a][i][41] ? 42'(-pj3[a][i]) : 42'(pj3[a][i]);
        rnd = (mag + HALF_D) >> F;
        c4_next[a][i] = rnd[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      ok4  <= ok4_next;
      lat4 <= lat4_next;
      c4   <= c4_next;
    end
  end

  // stage 5: extent products
  logic ok5;
  logic signed [LW-1:0] lat5 [2];
  logic [CW+23:0] ch5 [2][3];

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      ok5  <= ok4;
      lat5 <= lat4;
      for (int a = 0; a < 2; a++) begin
        ch5[a][0] <= c4[a][0] * hull_x;
        ch5[a][1] <= c4[a][1] * hull_y;
        ch5[a][2] <= c4[a][2] * hull_z;
      end
    end
  end

  // stage 6: projected extents
  logic ok6;
  logic signed [LW-1:0] lat6 [2];
  logic [PW-1:0] pw6 [2];

  always_ff @(posedge clk) begin
    logic [CW+25:0] s;
    if (rdy[6]) begin
      ok6  <= ok5;
      lat6 <= lat5;
      for (int a = 0; a < 2; a++) begin
        s = (CW+26)'(ch5[a][0]) + (CW+26)'(ch5[a][1]) + (CW+26)'(ch5[a][2]) + HALF_P;
        pw6[a] <= PW'(s >> F) + PW'(hull_clr);
      end
    end
  end

  // stage 7: clearances, status, saturation
  out_t out_next;

  always_comb begin
    logic [CLW-1:0] al [2];
    logic [CLW-1:0] pwx [2];
    logic [CLW-1:0] hs [2];
    logic [CLW-1:0] cl [2];
    logic [CLW-1:0] rad;
    logic [31:0] lsat [2];
    logic [31:0] csat [2];
    logic [PROJ_W-1:0] psat [2];
    logic sph;
    logic [2:0] st;
    hs[0] = CLW'(pass_w);
    hs[1] = CLW'(pass_h);
    rad   = CLW'(rad_root) + CLW'(hull_clr);
    sph   = 1'b1;
    for (int a = 0; a < 2; a++) begin
      al[a]  = lat6[a][LW-1] ? CLW'(-lat6[a]) : CLW'(lat6[a]);
      pwx[a] = CLW'(pw6[a]);
      cl[a]  = hs[a] - (al[a] + pwx[a]);
      if (al[a] + rad > hs[a]) sph = 1'b0;
      if ((&lat6[a][LW-1:31]) || !(|lat6[a][LW-1:31])) lsat[a] = lat6[a][31:0];
      else lsat[a] = lat6[a][LW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (!cl[a][CLW-1] && (|cl[a][CLW-2:28])) csat[a] = 32'h0FFF_FFFF;
      else if (cl[a][CLW-1] && !(&cl[a][CLW-2:31])) csat[a] = 32'h8000_0000;
      else csat[a] = cl[a][31:0];
      psat[a] = (|pw6[a][PW-1:PROJ_W]) ? '1 : pw6[a][PROJ_W-1:0];
    end
    if (pwx[0] > hs[0]) st = ST_TOO_WIDE;
    else if (pwx[1] > hs[1]) st = ST_TOO_TALL;
    else if (cl[0][CLW-1] || cl[1][CLW-1]) st = ST_OFFSET_OUT;
    else st = ST_FITS;
    if (ok6) begin
      out_next.status                = st;
      out_next.fits                  = (st == ST_FITS);
      out_next.sphere_fits           = sph;
      out_next.lateral_offset        = lsat[0];
      out_next.vertical_offset       = lsat[1];
      out_next.projected_half_width  = psat[0];
      out_next.projected_half_height = psat[1];
      out_next.width_clearance       = csat[0];
      out_next.height_clearance      = csat[1];
    end else begin
      out_next = '0;
      out_next.status = ST_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) out_data <= out_next;
  end

endmodule
`default_nettype wire

[src/obpc_radius.sv]
`timescale 1ns / 1ps
`default_nettype none
module obpc_radius import obpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [HULL_W-1:0] hx,
  input  wire logic [HULL_W-1:0] hy,
  input  wire logic [HULL_W-1:0] hz,
  output logic                   busy,
  output logic [ROOT_W-1:0]      root
);

  rad_state_t state, state_next;
  logic [4:0]  cnt;
  logic [49:0] acc;
  logic [49:0] x;
  logic [49:0] r;
  logic [HULL_W-1:0] hsel;
  logic [47:0] sq;
  logic [49:0] bitv;
  logic [49:0] trial;
  logic [49:0] x_n;
  logic [49:0] r_n;

  always_comb begin
    state_next = state;
    case (state)
      RAD_IDLE: begin
        if (start) state_next = RAD_SQUARE;
      end
      RAD_SQUARE: begin
        if (!start && cnt == 5'd2) state_next = RAD_ROOT;
      end
      RAD_ROOT: begin
        if (start) state_next = RAD_SQUARE;
        else if (cnt == 5'd0) state_next = RAD_IDLE;
      end
      default: state_next = RAD_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != RAD_IDLE);
  end

  always_comb begin
    case (cnt[1:0])
      2'd0: hsel = hx;
      2'd1: hsel = hy;
      default: hsel = hz;
    endcase
    sq    = hsel * hsel;
    bitv  = 50'(1) << {cnt, 1'b0};
    trial = r + bitv;
    if (x >= trial) begin
      x_n = x - trial;
      r_n = (r >> 1) + bitv;
    end else begin
      x_n = x;
      r_n = r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RAD_IDLE;
      cnt   <= '0;
      root  <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        cnt <= '0;
      end else if (state == RAD_SQUARE) begin
        cnt <= (cnt == 5'd2) ? 5'd24 : cnt + 5'd1;
      end else if (state == RAD_ROOT) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) root <= r_n[ROOT_W-1:0] + ROOT_W'(x_n != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (state == RAD_SQUARE) begin
      acc <= acc + 50'(sq);
      if (cnt == 5'd2) begin
        x <= acc + 50'(sq);
        r <= '0;
      end
    end else if (state == RAD_ROOT) begin
      x <= x_n;
      r <= r_n;
    end
  end

endmodule
`default_nettype wire

[verif/tb_oriented_box_passage_clearance_core.sv]
`timescale 1ns / 1ps
module tb_oriented_box_passage_clearance_core;
  import obpc_pkg::*;

  localparam longint ONE = 262144;
  localparam longint TOL = 68719;
  localparam longint PROJ_MAX = 67108863;
  localparam longint CLR_MAX = 268435455;
  localparam longint HULL_MAX = 16777215;
  localparam longint PASS_MAX = 268435455;
  localparam longint S32_MAX = 2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 150;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } v3_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HULL_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  longint hull_x, hull_y, hull_z, hull_clr, half_w, half_h;
  out_t result_q[$];
  bit typed_row = 1'b0;
  out_t typed_result = '0;
  bit calm = 1'b0;
  int errors = 0;
  int cycles = 0;

  in_t row_in[$];
  bit row_typed[$];
  out_t row_out[$];

  oriented_box_passage_clearance_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round to nearest, ties up
  function automatic longint round_sh(longint v, int s);
    longint w;
    w = v + (longint'(1) <<< (s - 1));
    return w >>> s;
  endfunction

  function automatic v3_t unpack_vec(logic [VEC_W-1:0] p);
    v3_t v;
    v.x = longint'($signed(p[19:0]));
    v.y = longint'($signed(p[39:20]));
    v.z = longint'($signed(p[59:40]));
    return v;
  endfunction

  function automatic logic [VEC_W-1:0] pack_vec(v3_t v);
    return {v.z[19:0], v.y[19:0], v.x[19:0]};
  endfunction

  function automatic longint dot(v3_t a, v3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic bit frame_ok(v3_t r, v3_t u, v3_t f);
    return iabs(dot(r, r) - ONE * ONE) <= TOL && iabs(dot(u, u) - ONE * ONE) <= TOL &&
      iabs(dot(f, f) - ONE * ONE) <= TOL && iabs(dot(r, u)) <= TOL &&
      iabs(dot(r, f)) <= TOL && iabs(dot(u, f)) <= TOL;
  endfunction

  function automatic longint extent_on(v3_t r, v3_t u, v3_t f, v3_t axis);
    longint acc;
    acc = round_sh(iabs(dot(r, axis)), 18) * hull_x + round_sh(iabs(dot(u, axis)), 18) * hull_y
      + round_sh(iabs(dot(f, axis)), 18) * hull_z;
    return ((acc + (ONE >> 1)) >>> 18) + hull_clr;
  endfunction

  function automatic longint sqrt_up(longint s);
    longint r;
    r = longint'($sqrt(real'(s)));
    while (r * r > s) r--;
    while (r * r < s) r++;
    return r;
  endfunction

  function automatic out_t clearance_of(in_t d);
    v3_t br, bu, bf, gr, gu, gf, rel;
    longint lat, vert, pw, ph, wc, hc, rad;
    out_t o;
    o = '0;
    br = unpack_vec(d.body_right);
    bu = unpack_vec(d.body_up);
    bf = unpack_vec(d.body_forward);
    gr = unpack_vec(d.gate_right);
    gu = unpack_vec(d.gate_up);
    gf = unpack_vec(d.gate_forward);
    if (!frame_ok(br, bu, bf) || !frame_ok(gr, gu, gf) || half_w == 0 || half_h == 0)
      return o;
    rel.x = longint'(d.pose_center_x) - longint'(d.gate_center_x);
    rel.y = longint'(d.pose_center_y) - longint'(d.gate_center_y);
    rel.z = longint'(d.pose_center_z) - longint'(d.gate_center_z);
    lat = round_sh(dot(rel, gr), 18);
    vert = round_sh(dot(rel, gu), 18);
    pw = extent_on(br, bu, bf, gr);
    ph = extent_on(br, bu, bf, gu);
    wc = half_w - (iabs(lat) + pw);
    hc = half_h - (iabs(vert) + ph);
    rad = sqrt_up(hull_x * hull_x + hull_y * hull_y + hull_z * hull_z) + hull_clr;
    if (pw > half_w) o.status = ST_TOO_WIDE;
    else if (ph > half_h) o.status = ST_TOO_TALL;
    else if (wc < 0 || hc < 0) o.status = ST_OFFSET_OUT;
    else o.status = ST_FITS;
    o.fits = o.status == ST_FITS;
    o.sphere_fits = iabs(lat) + rad <= half_w && iabs(vert) + rad <= half_h;
    o.lateral_offset = 32'(sat(lat, S32_MIN, S32_MAX));
    o.vertical_offset = 32'(sat(vert, S32_MIN, S32_MAX));
    o.projected_half_width = PROJ_W'(sat(pw, 0, PROJ_MAX));
    o.projected_half_height = PROJ_W'(sat(ph, 0, PROJ_MAX));
    o.width_clearance = 32'(sat(wc, S32_MIN, CLR_MAX));
    o.height_clearance = 32'(sat(hc, S32_MIN, CLR_MAX));
    return o;
  endfunction

  function automatic v3_t v3(longint x, longint y, longint z);
    v3_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  // near-unit rotation pair with c^2 + s^2 inside the unit tolerance
  task automatic rot_pair(output longint c, output longint s);
    longint err;
    do begin
      c = $urandom_range(0, 3) == 0 ? ONE * $urandom_range(0, 1) : $urandom_range(0, ONE);
      s = longint'($rtoi($sqrt(real'(ONE * ONE - c * c)) + 0.5));
      err = c * c + s * s - ONE * ONE;
    end while (iabs(err) > TOL);
    if ($urandom_range(0, 1)) c = -c;
    if ($urandom_range(0, 1)) s = -s;
  endtask

  task automatic make_frame(output v3_t r, output v3_t u, output v3_t f);
    longint c, s;
    longint m[3][3];
    longint row[3];
    v3_t v[3], t;
    int k, i, j;
    rot_pair(c, s);
    m[0] = '{c, s, 0};
    m[1] = '{-s, c, 0};
    m[2] = '{0, 0, ONE};
    k = $urandom_range(0, 2);
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) row[(j + k) % 3] = m[i][j];
      v[i] = v3(row[0], row[1], row[2]);
      if ($urandom_range(0, 1)) v[i] = v3(-row[0], -row[1], -row[2]);
    end
    for (i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = v[i];
      v[i] = v[j];
      v[j] = t;
    end
    r = v[0];
    u = v[1];
    f = v[2];
  endtask

  function automatic logic [VEC_W-1:0] rand_vec();
    return VEC_W'({$urandom, $urandom});
  endfunction

  function automatic longint rand_span(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    return 32'(sat(v, S32_MIN, S32_MAX));
  endfunction

  task automatic make_item(output in_t d);
    v3_t r, u, f;
    logic [VEC_W-1:0] vecs[6];
    longint span;
    int mode, k;
    make_frame(r, u, f);
    vecs[0] = pack_vec(r);
    vecs[1] = pack_vec(u);
    vecs[2] = pack_vec(f);
    make_frame(r, u, f);
    vecs[3] = pack_vec(r);
    vecs[4] = pack_vec(u);
    vecs[5] = pack_vec(f);
    mode = $urandom_range(0, 9);
    k = $urandom_range(0, 5);
    if (mode == 0) begin
      foreach (vecs[i]) vecs[i] = rand_vec();
    end else if (mode == 1) begin
      case ($urandom_range(0, 2))
        0: vecs[k] = rand_vec();
        1: vecs[k][19:0] = vecs[k][19:0] + 20'($urandom_range(1, 4));
        default: vecs[k] = vecs[(k / 3) * 3 + (k + 1) % 3];
      endcase
    end
    d.body_right = vecs[0];
    d.body_up = vecs[1];
    d.body_forward = vecs[2];
    d.gate_right = vecs[3];
    d.gate_up = vecs[4];
    d.gate_forward = vecs[5];
    if (mode == 0 || $urandom_range(0, 15) == 0) begin
      d.pose_center_x = $urandom;
      d.pose_center_y = $urandom;
      d.pose_center_z = $urandom;
      d.gate_center_x = $urandom;
      d.gate_center_y = $urandom;
      d.gate_center_z = $urandom;
    end else begin
      span = sat(2 * (half_w > half_h ? half_w : half_h) + 4096, 1, 1 << 30);
      d.gate_center_x = 32'(rand_span(1 << 24));
      d.gate_center_y = 32'(rand_span(1 << 24));
      d.gate_center_z = 32'(rand_span(1 << 24));
      d.pose_center_x = clamp32(longint'(d.gate_center_x) + rand_span(span));
      d.pose_center_y = clamp32(longint'(d.gate_center_y) + rand_span(span));
      d.pose_center_z = clamp32(longint'(d.gate_center_z) + rand_span(span));
    end
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic send(in_t d, bit typed, out_t e);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    typed_row = typed;
    typed_result = e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_hull(longint x, longint y, longint z, longint clr, longint w, longint h);
    cfg_write(CFG_HULL_X, x);
    cfg_write(CFG_HULL_Y, y);
    cfg_write(CFG_HULL_Z, z);
    cfg_write(CFG_HULL_CLR, clr);
    cfg_write(CFG_PASS_HALF_W, w);
    cfg_write(CFG_PASS_HALF_H, h);
  endtask

  task automatic add_row(in_t d, bit typed);
    row_in.push_back(d);
    row_typed.push_back(typed);
    row_out.push_back('0);
  endtask

  function automatic in_t frame_item(v3_t br, v3_t bu, v3_t bf, longint px, longint py,
                                     longint pz, longint gx, longint gy, longint gz);
    in_t d;
    d.body_right = pack_vec(br);
    d.body_up = pack_vec(bu);
    d.body_forward = pack_vec(bf);
    d.gate_right = pack_vec(v3(ONE, 0, 0));
    d.gate_up = pack_vec(v3(0, ONE, 0));
    d.gate_forward = pack_vec(v3(0, 0, ONE));
    d.pose_center_x = 32'(px);
    d.pose_center_y = 32'(py);
    d.pose_center_z = 32'(pz);
    d.gate_center_x = 32'(gx);
    d.gate_center_y = 32'(gy);
    d.gate_center_z = 32'(gz);
    return d;
  endfunction

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HULL_X: hull_x = longint'(cfg_data[HULL_W-1:0]);
        CFG_HULL_Y: hull_y = longint'(cfg_data[HULL_W-1:0]);
        CFG_HULL_Z: hull_z = longint'(cfg_data[HULL_W-1:0]);
        CFG_HULL_CLR: hull_clr = longint'(cfg_data[HULL_W-1:0]);
        CFG_PASS_HALF_W: half_w = longint'(cfg_data[PASS_W-1:0]);
        CFG_PASS_HALF_H: half_h = longint'(cfg_data[PASS_W-1:0]);
        default: ;
      endcase
    end
    if (!rst && in_valid && in_ready)
      result_q.push_back(typed_row ? typed_result : clearance_of(in_data));
  end

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected transaction expected none actual %h", $time, out_data);
        errors++;
      end else begin
        e = result_q.pop_front();
        check_field("status", e.status, out_data.status);
        check_field("fits", e.fits, out_data.fits);
        check_field("sphere_fits", e.sphere_fits, out_data.sphere_fits);
        check_field("lateral_offset", e.lateral_offset, out_data.lateral_offset);
        check_field("vertical_offset", e.vertical_offset, out_data.vertical_offset);
        check_field("projected_half_width", e.projected_half_width,
                    out_data.projected_half_width);
        check_field("projected_half_height", e.projected_half_height,
                    out_data.projected_half_height);
        check_field("width_clearance", e.width_clearance, out_data.width_clearance);
        check_field("height_clearance", e.height_clearance, out_data.height_clearance);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, result_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver with random stalls
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    in_t d;
    v3_t ex, ey, ez;
    int phase;
    hull_x = 0; hull_y = 0; hull_z = 0; hull_clr = 0; half_w = 0; half_h = 0;
    ex = v3(ONE, 0, 0);
    ey = v3(0, ONE, 0);
    ez = v3(0, 0, ONE);

    // first row runs at reset settings: zero passage size is invalid
    add_row(frame_item(ex, ey, ez, 0, 0, 0, 0, 0, 0), 1'b1);
    add_row(frame_item(ex, ey, ez, 0, 0, 0, 0, 0, 0), 1'b0);
    add_row(frame_item(ex, ey, ez, 9 * 4096, 0, 0, 0, 0, 0), 1'b0);
    add_row(frame_item(ez, ey, ex, 0, 0, 0, 0, 0, 0), 1'b0);
    add_row(frame_item(ex, ez, ey, 0, 0, 0, 0, 0, 0), 1'b0);
    add_row(frame_item(ex, ey, ez, 8 * 4096 - 256 - 12 * 4096, 0, 0, 0, 0, 0), 1'b0);
    add_row(frame_item(ex, ey, ez, 0, -5 * 4096, 7, 0, 0, 0), 1'b0);
    add_row(frame_item(ex, ey, ez, S32_MAX, S32_MAX, S32_MAX,
                       S32_MIN, S32_MIN, S32_MIN), 1'b0);
    add_row(frame_item(ex, ey, ez, S32_MIN, S32_MIN, S32_MIN,
                       S32_MAX, S32_MAX, S32_MAX), 1'b0);
    add_row(frame_item(v3(-ONE, 0, 0), v3(0, -ONE, 0), v3(0, 0, -ONE), 3, -3, 1, 0, 0, 0),
            1'b0);
    d = frame_item(ex, ey, ez, 0, 0, 0, 0, 0, 0);
    d.gate_up = pack_vec(v3(ONE, 0, 0));
    add_row(d, 1'b1);
    d = frame_item(ex, ex, ez, 0, 0, 0, 0, 0, 0);
    add_row(d, 1'b1);
    d = frame_item(v3(524287, -524288, 524287), ey, ez, 0, 0, 0, 0, 0, 0);
    add_row(d, 1'b1);
    d = frame_item(ex, ey, ez, 0, 0, 0, 0, 0, 0);
    d.gate_forward = {60{1'b1}};
    add_row(d, 1'b1);
    for (int i = 0; i < 4; i++) begin
      make_item(d);
      add_row(d, 1'b0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (row_in[i]) begin
      if (i == 1) begin
        drain();
        set_hull(2 * 4096, 4096, 12 * 4096, 256, 10 * 4096, 6 * 4096);
      end
      send(row_in[i], row_typed[i], row_out[i]);
    end

    for (phase = 0; phase < 7; phase++) begin
      drain();
      case (phase)
        0: set_hull($urandom_range(0, 1 << 14), $urandom_range(0, 1 << 14),
                    $urandom_range(0, 1 << 14), $urandom_range(0, 1 << 10),
                    $urandom_range(1, 1 << 16), $urandom_range(1, 1 << 16));
        1: set_hull(HULL_MAX, HULL_MAX, HULL_MAX, HULL_MAX, PASS_MAX, PASS_MAX);
        2: set_hull(0, 0, 0, 0, 1, 1);
        3: set_hull($urandom_range(0, 1 << 14), 0, $urandom_range(0, 1 << 14), 0,
                    0, $urandom_range(1, 1 << 16));
        4: set_hull($urandom_range(0, HULL_MAX), $urandom_range(0, HULL_MAX),
                    $urandom_range(0, HULL_MAX), $urandom_range(0, HULL_MAX),
                    $urandom_range(1, PASS_MAX), $urandom_range(1, PASS_MAX));
        5: set_hull(HULL_MAX, 1, 0, 0, PASS_MAX, $urandom_range(1, 1 << 20));
        default: set_hull($urandom_range(0, 1 << 16), $urandom_range(0, 1 << 16),
                          $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 12),
                          $urandom_range(1 << 12, 1 << 20), $urandom_range(1 << 12, 1 << 20));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 39) == 0) calm = !calm;
        make_item(d);
        send(d, 1'b0, '0);
      end
    end

    calm = 1'b0;
    in_valid = 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
